// ----- design/uart_frame_receiver_ring_top_defines.svh -----
// Assertion helpers for the frame receiver ring.
`ifndef UART_FRAME_RECEIVER_RING_TOP_DEFINES_SVH
`define UART_FRAME_RECEIVER_RING_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define UFR_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define UFR_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/ufr_pkg.sv -----
package ufr_pkg;

  // Command codes of one input transfer
  typedef enum logic [1:0] {
    CMD_RX      = 2'd0,
    CMD_TICK    = 2'd1,
    CMD_READ    = 2'd2,
    CMD_RELEASE = 2'd3
  } cmd_t;

  // Per-slot status
  typedef enum logic [1:0] {
    ST_FREE  = 2'd0,
    ST_RECV  = 2'd1,
    ST_READY = 2'd2
  } slot_status_t;

  localparam logic [7:0] START_BYTE    = 8'hAA;
  localparam logic [7:0] HEADER_BYTES  = 8'd5;
  localparam logic [7:0] TIMEOUT_RESET = 8'd10;
  localparam logic [8:0] LENGTH_MAX    = 9'd511;

  // Config register index
  localparam logic REG_TIMEOUT = 1'b0;

endpackage

// ----- design/ufr_ram.sv -----
module ufr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/uart_frame_receiver_ring_top.sv -----
// UART frame receiver ring: takes one command transfer per clock while in_ready is
// high (received byte, timer tick, read of a ready frame byte, release of the lowest
// ready frame) and returns one result per command. Each command is applied to the slot
// state in the cycle it is accepted; its result passes the stage-one registers and the
// frame store read (a RAM with a registered read port), then the output register.
// Throughput is one command per cycle; an unaccepted output holds the pipeline.
// The timeout register sits at APB byte address 0 and resets to 10. The frame store
// has no reset; only bytes below a ready frame's length are ever read back.
`include "uart_frame_receiver_ring_top_defines.svh"

module uart_frame_receiver_ring_top #(
  parameter int SLOTS       = 4,
  parameter int FRAME_BYTES = 512
) (
  input  logic        clk,
  input  logic        rst,
  // APB config
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // command channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [7:0]  rx_byte,
  input  logic [8:0]  read_index,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        frame_ready,
  output logic [1:0]  ready_slot,
  output logic [8:0]  ready_length,
  output logic [7:0]  read_data,
  output logic        frame_done,
  output logic        timeout_hit
);

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int DEPTH  = SLOTS * FRAME_BYTES;
  localparam int ADDR_W = $clog2(DEPTH);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_HEAD = 2'd1,
    PH_DATA = 2'd2
  } phase_t;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] idx;
  } lowest_t;

  // Architectural state
  logic [7:0]            timeout_limit;
  ufr_pkg::slot_status_t status [SLOTS];
  logic [8:0]            slot_length [SLOTS];
  logic [SLOT_W-1:0]     fill_slot;
  phase_t                rx_phase;
  logic [7:0]            bytes_left;
  logic [7:0]            tick_count;

  ufr_pkg::slot_status_t status_next [SLOTS];
  logic [8:0]            slot_length_next [SLOTS];
  logic [SLOT_W-1:0]     fill_slot_next;
  phase_t                rx_phase_next;
  logic [7:0]            bytes_left_next;
  logic [7:0]            tick_count_next;

  // Pipeline registers
  logic              s1_valid;
  logic              s1_frame_ready;
  logic [SLOT_W-1:0] s1_slot;
  logic [8:0]        s1_len;
  logic              s1_rd;
  logic              s1_done;
  logic              s1_hit;

  logic              accept;
  logic              advance;
  logic              cfg_wr;
  lowest_t           cur_low;
  lowest_t           nxt_low;
  logic [8:0]        wr_pos;
  logic              wr_en;
  logic              rd_ok;
  logic              done;
  logic              hit;
  logic              finish;
  logic [7:0]        bl_dec;
  logic [8:0]        tick_inc;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        ram_q;
  logic [SLOT_W+1:0] slot_ext;

  // Lowest numbered ready slot
  function automatic lowest_t find_lowest(input ufr_pkg::slot_status_t st [SLOTS]);
    lowest_t res;
    res = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (st[i] == ufr_pkg::ST_READY) begin
        res.found = 1'b1;
        res.idx   = SLOT_W'(i);
      end
    end
    return res;
  endfunction

  // Handshake and config port
  assign advance = !out_valid || out_ready;
  assign in_ready = advance;
  assign accept   = in_valid && in_ready;
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready && (paddr[2] == ufr_pkg::REG_TIMEOUT);
  assign prdata   = (paddr[2] == ufr_pkg::REG_TIMEOUT) ? {24'd0, timeout_limit} : 32'd0;

  assign cur_low = find_lowest(status);

  // Next state for the accepted command
  always_comb begin
    status_next      = status;
    slot_length_next = slot_length;
    fill_slot_next   = fill_slot;
    rx_phase_next    = rx_phase;
    bytes_left_next  = bytes_left;
    tick_count_next  = tick_count;
    wr_pos           = slot_length[fill_slot];
    wr_en            = 1'b0;
    rd_ok            = 1'b0;
    done             = 1'b0;
    hit              = 1'b0;
    finish           = 1'b0;
    bl_dec           = bytes_left - 8'd1;
    tick_inc         = {1'b0, tick_count} + 9'd1;
    if (accept) begin
      case (ufr_pkg::cmd_t'(command))
        ufr_pkg::CMD_RX: begin
          if (rx_phase == PH_IDLE) begin
            if (rx_byte == ufr_pkg::START_BYTE && status[fill_slot] == ufr_pkg::ST_FREE) begin
              status_next[fill_slot]      = ufr_pkg::ST_RECV;
              wr_pos                      = 9'd0;
              wr_en                       = 1'b1;
              slot_length_next[fill_slot] = 9'd1;
              bytes_left_next             = ufr_pkg::HEADER_BYTES;
              tick_count_next             = 8'd1;
              rx_phase_next               = PH_HEAD;
            end
          end else begin
            wr_en = (32'(wr_pos) < FRAME_BYTES);
            if (slot_length[fill_slot] != ufr_pkg::LENGTH_MAX) begin
              slot_length_next[fill_slot] = slot_length[fill_slot] + 9'd1;
            end
            bytes_left_next = bl_dec;
            if (rx_phase == PH_HEAD) begin
              if (bl_dec == 8'd0) begin
                bytes_left_next = rx_byte;
                rx_phase_next   = PH_DATA;
                finish          = (rx_byte == 8'd0);
              end
            end else begin
              finish = (bl_dec == 8'd0);
            end
          end
        end
        ufr_pkg::CMD_TICK: begin
          if (rx_phase != PH_IDLE && tick_count != 8'd0) begin
            if (tick_inc > {1'b0, timeout_limit}) begin
              rx_phase_next          = PH_IDLE;
              status_next[fill_slot] = ufr_pkg::ST_FREE;
              tick_count_next        = 8'd0;
              hit                    = 1'b1;
            end else begin
              tick_count_next = tick_inc[7:0];
            end
          end
        end
        ufr_pkg::CMD_READ: begin
          rd_ok = cur_low.found && (read_index < slot_length[cur_low.idx])
                  && (32'(read_index) < FRAME_BYTES);
        end
        default: begin
          if (cur_low.found) begin
            status_next[cur_low.idx] = ufr_pkg::ST_FREE;
          end
        end
      endcase
      // Frame complete: mark ready and move round the ring
      if (finish) begin
        status_next[fill_slot] = ufr_pkg::ST_READY;
        fill_slot_next  = (32'(fill_slot) == SLOTS - 1) ? '0 : fill_slot + SLOT_W'(1);
        rx_phase_next   = PH_IDLE;
        tick_count_next = 8'd0;
        done            = 1'b1;
      end
    end
  end

  assign nxt_low = find_lowest(status_next);

  // Frame store addresses
  assign wr_addr = ADDR_W'(32'(fill_slot) * FRAME_BYTES + 32'(wr_pos));
  assign rd_addr = ADDR_W'(32'(cur_low.idx) * FRAME_BYTES + 32'(read_index));

  ufr_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (rx_byte),
    .re    (advance),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  // State, config and pipeline registers
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_limit <= ufr_pkg::TIMEOUT_RESET;
      for (int i = 0; i < SLOTS; i++) begin
        status[i]      <= ufr_pkg::ST_FREE;
        slot_length[i] <= 9'd0;
      end
      fill_slot  <= '0;
      rx_phase   <= PH_IDLE;
      bytes_left <= 8'd0;
      tick_count <= 8'd0;
      s1_valid   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr) begin
        timeout_limit <= pwdata[7:0];
      end
      status      <= status_next;
      slot_length <= slot_length_next;
      fill_slot   <= fill_slot_next;
      rx_phase    <= rx_phase_next;
      bytes_left  <= bytes_left_next;
      tick_count  <= tick_count_next;
      if (advance) begin
        s1_valid  <= accept;
        out_valid <= s1_valid;
      end
    end
  end

  assign slot_ext = {2'b00, s1_slot};

  // Payload registers
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_frame_ready <= nxt_low.found;
      s1_slot        <= nxt_low.found ? nxt_low.idx : '0;
      s1_len         <= nxt_low.found ? slot_length_next[nxt_low.idx] : 9'd0;
      s1_rd          <= rd_ok;
      s1_done        <= done;
      s1_hit         <= hit;
      frame_ready    <= s1_frame_ready;
      ready_slot     <= slot_ext[1:0];
      ready_length   <= s1_len;
      read_data      <= s1_rd ? ram_q : 8'd0;
      frame_done     <= s1_done;
      timeout_hit    <= s1_hit;
    end
  end

  // Checks
  `UFR_ASSERT_IMP(a_idle_no_ticks, clk, rst, rx_phase == PH_IDLE, tick_count == 8'd0,
    "tick count running while receiver idle")
  `UFR_ASSERT_IMP(a_fill_receiving, clk, rst, rx_phase != PH_IDLE,
    status[fill_slot] == ufr_pkg::ST_RECV, "frame under way in a slot not receiving")
  `UFR_ASSERT_NXT(a_stage_hold, clk, rst, s1_valid && !advance, s1_valid && $stable(s1_len),
    "stage one lost its transfer during a stall")
  `UFR_ASSERT_IMP(a_done_hit_excl, clk, rst, out_valid, !(frame_done && timeout_hit),
    "frame done and timeout in one result")

endmodule
